// ===== design/sgpm_pkg.sv =====
// Package for the stereo gain stage with peak meter.
// Holds the widths, item and register codes, stage types and the rounding,
// saturation and magnitude functions; every module in the design folder uses it.
package sgpm_pkg;

  // Fixed-point widths.
  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_FRAC_BITS = 13;
  localparam int GAIN_BITS      = 15;
  localparam int OUT_GAIN_BITS  = 14;
  localparam int DECAY_BITS     = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int MODE_BITS      = 2;
  // Signed sample times a gain extended by one sign bit.
  localparam int PROD_BITS      = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int PEAK_BITS      = SAMPLE_BITS;

  // Register reset values.
  localparam logic [GAIN_BITS-1:0]     GainReset  = GAIN_BITS'(8192);
  localparam logic [OUT_GAIN_BITS-1:0] OutGainReset = OUT_GAIN_BITS'(8192);
  localparam logic [DECAY_BITS-1:0]    DecayReset = DECAY_BITS'(55706);

  // Full-scale limits of a sample.
  localparam logic signed [SAMPLE_BITS-1:0] SampleMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SampleMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Half an LSB of the result, added before the right shift.
  localparam logic signed [PROD_BITS-1:0] RoundHalf = PROD_BITS'(1) <<< (GAIN_FRAC_BITS - 1);

  // Item kinds.
  typedef enum logic [MODE_BITS-1:0] {
    MODE_INPUT  = 2'd0,
    MODE_OUTPUT = 2'd1,
    MODE_DECAY  = 2'd2,
    MODE_IGNORE = 2'd3
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_INPUT_GAIN_LEFT  = 2'd0,
    REG_INPUT_GAIN_RIGHT = 2'd1,
    REG_OUTPUT_GAIN      = 2'd2,
    REG_DECAY_FACTOR     = 2'd3
  } cfg_reg_t;

  // Current register contents, handed from the register file to the datapath.
  typedef struct packed {
    logic [GAIN_BITS-1:0]     input_gain_left;
    logic [GAIN_BITS-1:0]     input_gain_right;
    logic [OUT_GAIN_BITS-1:0] output_gain;
    logic [DECAY_BITS-1:0]    decay_factor;
  } cfg_t;

  // Contents of the product stage.
  typedef struct packed {
    mode_t                       mode;
    logic signed [PROD_BITS-1:0] prod_left;
    logic signed [PROD_BITS-1:0] prod_right;
    logic                        buffer_end;
  } prod_stage_t;

  // A rounded and clamped sample with its clip flag.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          clip;
  } sat_t;

  // Round to nearest (ties up) by an arithmetic shift, then clamp to full scale.
  function automatic sat_t round_sat(input logic signed [PROD_BITS-1:0] prod);
    logic signed [PROD_BITS-1:0] shifted;
    sat_t                        res;
    shifted = (prod + RoundHalf) >>> GAIN_FRAC_BITS;
    if (shifted > PROD_BITS'(SampleMax)) begin
      res.value = SampleMax;
      res.clip  = 1'b1;
    end else if (shifted < PROD_BITS'(SampleMin)) begin
      res.value = SampleMin;
      res.clip  = 1'b1;
    end else begin
      res.value = shifted[SAMPLE_BITS-1:0];
      res.clip  = 1'b0;
    end
    return res;
  endfunction

  // Magnitude of a sample; the most negative code maps to 2^(SAMPLE_BITS-1).
  function automatic logic [PEAK_BITS-1:0] magnitude(input logic signed [SAMPLE_BITS-1:0] v);
    logic [PEAK_BITS-1:0] res;
    res = v[SAMPLE_BITS-1] ? PEAK_BITS'(-v) : PEAK_BITS'(v);
    return res;
  endfunction

endpackage

// ===== design/stereo_gain_peak_meter_top.sv =====
// Stereo gain stage with absolute peak-hold meters.
// Each input transaction passes through the product stage, then the result
// stage. Throughput: one transaction per cycle; each stage holds one
// transaction, so a stalled result blocks the input once both stages are full.
// Reset (synchronous, active high) empties both stages, clears the four peaks
// and loads the gain and decay registers with their defaults.
module stereo_gain_peak_meter_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [sgpm_pkg::MODE_BITS-1:0]          mode,
  input  logic signed [sgpm_pkg::SAMPLE_BITS-1:0] left_sample,
  input  logic signed [sgpm_pkg::SAMPLE_BITS-1:0] right_sample,
  input  logic                                    buffer_end,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [sgpm_pkg::SAMPLE_BITS-1:0] left_result,
  output logic signed [sgpm_pkg::SAMPLE_BITS-1:0] right_result,
  output logic                                    saturated,
  output logic                                    buffer_end_out,
  output logic [sgpm_pkg::PEAK_BITS-1:0]          peak_input_left,
  output logic [sgpm_pkg::PEAK_BITS-1:0]          peak_input_right,
  output logic [sgpm_pkg::PEAK_BITS-1:0]          peak_output_left,
  output logic [sgpm_pkg::PEAK_BITS-1:0]          peak_output_right,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [sgpm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [sgpm_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  sgpm_pkg::cfg_t        cfg;
  sgpm_pkg::prod_stage_t stage;
  logic                  stage_valid;
  logic                  advance;

  // Register writes complete in the cycle they are offered.
  assign cfg_ready = 1'b1;

  sgpm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sgpm_mult u_mult (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .buffer_end   (buffer_end),
    .cfg          (cfg),
    .advance      (advance),
    .stage_valid  (stage_valid),
    .stage        (stage)
  );

  sgpm_meter u_meter (
    .clk               (clk),
    .rst               (rst),
    .stage_valid       (stage_valid),
    .stage             (stage),
    .decay_factor      (cfg.decay_factor),
    .out_ready         (out_ready),
    .advance           (advance),
    .out_valid         (out_valid),
    .left_result       (left_result),
    .right_result      (right_result),
    .saturated         (saturated),
    .buffer_end_out    (buffer_end_out),
    .peak_input_left   (peak_input_left),
    .peak_input_right  (peak_input_right),
    .peak_output_left  (peak_output_left),
    .peak_output_right (peak_output_right)
  );

endmodule

// ===== design/sgpm_cfg.sv =====
// Configuration register file of the stereo gain stage.
// Depends on sgpm_pkg for the register indexes, widths and reset values.
module sgpm_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [sgpm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [sgpm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output sgpm_pkg::cfg_t                       cfg
);

  // Each transaction writes one register, masked to its width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.input_gain_left  <= sgpm_pkg::GainReset;
      cfg.input_gain_right <= sgpm_pkg::GainReset;
      cfg.output_gain      <= sgpm_pkg::OutGainReset;
      cfg.decay_factor     <= sgpm_pkg::DecayReset;
    end else if (cfg_valid) begin
      unique case (sgpm_pkg::cfg_reg_t'(cfg_index))
        sgpm_pkg::REG_INPUT_GAIN_LEFT: begin
          cfg.input_gain_left <= cfg_data[sgpm_pkg::GAIN_BITS-1:0];
        end
        sgpm_pkg::REG_INPUT_GAIN_RIGHT: begin
          cfg.input_gain_right <= cfg_data[sgpm_pkg::GAIN_BITS-1:0];
        end
        sgpm_pkg::REG_OUTPUT_GAIN: begin
          cfg.output_gain <= cfg_data[sgpm_pkg::OUT_GAIN_BITS-1:0];
        end
        sgpm_pkg::REG_DECAY_FACTOR: begin
          cfg.decay_factor <= cfg_data[sgpm_pkg::DECAY_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/sgpm_mult.sv =====
// Product stage: selects each channel's gain and registers the exact products.
// Depends on sgpm_pkg for the stage and configuration types.
module sgpm_mult (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [sgpm_pkg::MODE_BITS-1:0]       mode,
  input  logic signed [sgpm_pkg::SAMPLE_BITS-1:0] left_sample,
  input  logic signed [sgpm_pkg::SAMPLE_BITS-1:0] right_sample,
  input  logic                                 buffer_end,
  input  sgpm_pkg::cfg_t                       cfg,
  input  logic                                 advance,
  output logic                                 stage_valid,
  output sgpm_pkg::prod_stage_t                stage
);

  logic [sgpm_pkg::GAIN_BITS-1:0]       gain_left;
  logic [sgpm_pkg::GAIN_BITS-1:0]       gain_right;
  logic signed [sgpm_pkg::PROD_BITS-1:0] prod_left;
  logic signed [sgpm_pkg::PROD_BITS-1:0] prod_right;
  logic                                 accept;

  // The stage takes a new transaction when empty or when it drains this cycle.
  assign in_ready = !stage_valid || advance;
  assign accept   = in_valid && in_ready;

  // Input-path frames use per-channel gains; all else uses the common gain.
  always_comb begin
    if (sgpm_pkg::mode_t'(mode) == sgpm_pkg::MODE_INPUT) begin
      gain_left  = cfg.input_gain_left;
      gain_right = cfg.input_gain_right;
    end else begin
      gain_left  = sgpm_pkg::GAIN_BITS'(cfg.output_gain);
      gain_right = sgpm_pkg::GAIN_BITS'(cfg.output_gain);
    end
  end

  // Signed sample times unsigned gain, one multiplier per channel.
  assign prod_left  = sgpm_pkg::PROD_BITS'(left_sample) *
                      sgpm_pkg::PROD_BITS'(signed'({1'b0, gain_left}));
  assign prod_right = sgpm_pkg::PROD_BITS'(right_sample) *
                      sgpm_pkg::PROD_BITS'(signed'({1'b0, gain_right}));

  // Stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      stage.mode       <= sgpm_pkg::mode_t'(mode);
      stage.prod_left  <= prod_left;
      stage.prod_right <= prod_right;
      stage.buffer_end <= buffer_end;
    end
  end

endmodule

// ===== design/sgpm_meter.sv =====
// Result stage: rounds and saturates the products, updates or decays the four
// peak-hold registers and holds the result. Depends on sgpm_pkg.
module sgpm_meter (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    stage_valid,
  input  sgpm_pkg::prod_stage_t                   stage,
  input  logic [sgpm_pkg::DECAY_BITS-1:0]         decay_factor,
  input  logic                                    out_ready,
  output logic                                    advance,
  output logic                                    out_valid,
  output logic signed [sgpm_pkg::SAMPLE_BITS-1:0] left_result,
  output logic signed [sgpm_pkg::SAMPLE_BITS-1:0] right_result,
  output logic                                    saturated,
  output logic                                    buffer_end_out,
  output logic [sgpm_pkg::PEAK_BITS-1:0]          peak_input_left,
  output logic [sgpm_pkg::PEAK_BITS-1:0]          peak_input_right,
  output logic [sgpm_pkg::PEAK_BITS-1:0]          peak_output_left,
  output logic [sgpm_pkg::PEAK_BITS-1:0]          peak_output_right
);

  localparam int DecayProdBits = sgpm_pkg::PEAK_BITS + sgpm_pkg::DECAY_BITS;

  // Held peaks; the output peak fields copy these after each update.
  logic [sgpm_pkg::PEAK_BITS-1:0] held_in_left,  held_in_left_next;
  logic [sgpm_pkg::PEAK_BITS-1:0] held_in_right, held_in_right_next;
  logic [sgpm_pkg::PEAK_BITS-1:0] held_out_left,  held_out_left_next;
  logic [sgpm_pkg::PEAK_BITS-1:0] held_out_right, held_out_right_next;

  sgpm_pkg::sat_t                 sat_left;
  sgpm_pkg::sat_t                 sat_right;
  logic [sgpm_pkg::PEAK_BITS-1:0] mag_left;
  logic [sgpm_pkg::PEAK_BITS-1:0] mag_right;
  logic [DecayProdBits-1:0]       dec_in_left, dec_in_right, dec_out_left, dec_out_right;
  logic signed [sgpm_pkg::SAMPLE_BITS-1:0] left_next, right_next;
  logic                           saturated_next;
  logic                           load;

  // The result register moves when empty or when its transaction is taken.
  assign advance = !out_valid || out_ready;
  assign load    = advance && stage_valid;

  // Rounding, saturation and magnitudes of both channels.
  assign sat_left  = sgpm_pkg::round_sat(stage.prod_left);
  assign sat_right = sgpm_pkg::round_sat(stage.prod_right);
  assign mag_left  = sgpm_pkg::magnitude(sat_left.value);
  assign mag_right = sgpm_pkg::magnitude(sat_right.value);

  // Decayed peaks, floor(peak * factor / 2^16).
  assign dec_in_left   = DecayProdBits'(held_in_left)   * DecayProdBits'(decay_factor);
  assign dec_in_right  = DecayProdBits'(held_in_right)  * DecayProdBits'(decay_factor);
  assign dec_out_left  = DecayProdBits'(held_out_left)  * DecayProdBits'(decay_factor);
  assign dec_out_right = DecayProdBits'(held_out_right) * DecayProdBits'(decay_factor);

  // Next peaks and result samples for the transaction in the product stage.
  always_comb begin
    held_in_left_next   = held_in_left;
    held_in_right_next  = held_in_right;
    held_out_left_next  = held_out_left;
    held_out_right_next = held_out_right;
    left_next           = '0;
    right_next          = '0;
    saturated_next      = 1'b0;
    case (stage.mode)
      sgpm_pkg::MODE_INPUT: begin
        left_next      = sat_left.value;
        right_next     = sat_right.value;
        saturated_next = sat_left.clip || sat_right.clip;
        if (mag_left > held_in_left) begin
          held_in_left_next = mag_left;
        end
        if (mag_right > held_in_right) begin
          held_in_right_next = mag_right;
        end
      end
      sgpm_pkg::MODE_OUTPUT: begin
        left_next      = sat_left.value;
        right_next     = sat_right.value;
        saturated_next = sat_left.clip || sat_right.clip;
        if (mag_left > held_out_left) begin
          held_out_left_next = mag_left;
        end
        if (mag_right > held_out_right) begin
          held_out_right_next = mag_right;
        end
      end
      sgpm_pkg::MODE_DECAY: begin
        held_in_left_next   = dec_in_left[DecayProdBits-1:sgpm_pkg::DECAY_BITS];
        held_in_right_next  = dec_in_right[DecayProdBits-1:sgpm_pkg::DECAY_BITS];
        held_out_left_next  = dec_out_left[DecayProdBits-1:sgpm_pkg::DECAY_BITS];
        held_out_right_next = dec_out_right[DecayProdBits-1:sgpm_pkg::DECAY_BITS];
      end
      default: begin
        // The unused code leaves all state as it is and returns zero samples.
      end
    endcase
  end

  // Peak-hold state.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_in_left   <= '0;
      held_in_right  <= '0;
      held_out_left  <= '0;
      held_out_right <= '0;
    end else if (load) begin
      held_in_left   <= held_in_left_next;
      held_in_right  <= held_in_right_next;
      held_out_left  <= held_out_left_next;
      held_out_right <= held_out_right_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      left_result       <= left_next;
      right_result      <= right_next;
      saturated         <= saturated_next;
      buffer_end_out    <= stage.buffer_end;
      peak_input_left   <= held_in_left_next;
      peak_input_right  <= held_in_right_next;
      peak_output_left  <= held_out_left_next;
      peak_output_right <= held_out_right_next;
    end
  end

endmodule

// ===== design/sgpm_checker.sv =====
// Port-level checker for the stereo gain stage, bound to the top level.
// Depends on sgpm_pkg for widths and full-scale limits.
module sgpm_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    in_valid,
  input logic                                    in_ready,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic signed [sgpm_pkg::SAMPLE_BITS-1:0] left_result,
  input logic signed [sgpm_pkg::SAMPLE_BITS-1:0] right_result,
  input logic                                    saturated,
  input logic [sgpm_pkg::PEAK_BITS-1:0]          peak_input_left,
  input logic [sgpm_pkg::PEAK_BITS-1:0]          peak_input_right,
  input logic [sgpm_pkg::PEAK_BITS-1:0]          peak_output_left,
  input logic [sgpm_pkg::PEAK_BITS-1:0]          peak_output_right
);

  localparam logic [sgpm_pkg::PEAK_BITS-1:0] PeakMax = {1'b1, {(sgpm_pkg::PEAK_BITS-1){1'b0}}};

  // A stalled result keeps its transaction.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_result) && $stable(right_result))
    else $error("result changed while stalled");

  // A new result follows an accepted transaction that passed through the product stage.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without an input transaction");

  // A clip flag goes with a full-scale sample.
  a_clip_fullscale: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (left_result == sgpm_pkg::SampleMax) || (left_result == sgpm_pkg::SampleMin) ||
      (right_result == sgpm_pkg::SampleMax) || (right_result == sgpm_pkg::SampleMin))
    else $error("clip flag without full-scale sample");

  // Held peaks never exceed full-scale magnitude.
  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (peak_input_left <= PeakMax) && (peak_input_right <= PeakMax) &&
                  (peak_output_left <= PeakMax) && (peak_output_right <= PeakMax))
    else $error("peak beyond full scale");

endmodule

bind stereo_gain_peak_meter_top sgpm_checker u_sgpm_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .left_result       (left_result),
  .right_result      (right_result),
  .saturated         (saturated),
  .peak_input_left   (peak_input_left),
  .peak_input_right  (peak_input_right),
  .peak_output_left  (peak_output_left),
  .peak_output_right (peak_output_right)
);
